// ===== rtl/bust_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants for the bounded unique set table.
// Used by bust_cell and bounded_unique_set_table_unit; depends on nothing.
package bust_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int SLOT_W        = 4;
  localparam int COUNT_W       = 5;
  localparam int HIT_W         = COUNT_W;

  localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  entry_count;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic               hit;
    logic [HIT_W-1:0]   hit_slot;
    logic [VALUE_W-1:0] tail;
  } probe_t;

  typedef struct packed {
    logic               en;
    logic [HIT_W-1:0]   slot;
    logic [VALUE_W-1:0] data;
  } wr_t;

endpackage

// ===== rtl/bust_cell.sv =====
`timescale 1ns / 1ps
// One cell of the set table: holds one entry and forwards the search probe.
// Depends on bust_pkg.
module bust_cell import bust_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] count,
  input  probe_t             probe_in,
  input  wr_t                wr,
  output probe_t             probe_out
);

  logic [VALUE_W-1:0] entry;
  logic               in_range;
  logic               is_tail;
  logic               match;

  assign in_range = IDX < 32'(count);
  assign is_tail  = (32'(IDX) + 32'd1) == 32'(count);
  assign match    = in_range && !probe_in.hit && (entry == probe_in.value);

  always_ff @(posedge clk) begin
    if (wr.en && (32'(wr.slot) == 32'(IDX))) begin
      entry <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
    end
    probe_out.value    <= probe_in.value;
    probe_out.hit      <= probe_in.hit | match;
    probe_out.hit_slot <= match ? HIT_W'(IDX) : probe_in.hit_slot;
    probe_out.tail     <= is_tail ? entry : probe_in.tail;
  end

endmodule

// ===== rtl/bounded_unique_set_table_unit.sv =====
`timescale 1ns / 1ps
// Top level of the bounded unique set table: a row of DEPTH cells and control.
// Depends on bust_pkg and bust_cell.
//
// Every command walks a probe down the row of DEPTH cells, one cell per cycle,
// gathering the match slot and the last held entry, then writes back as the
// probe leaves the last cell. A command's result word, with done high, appears
// in the same cycle that busy falls, so a new command is taken only from then on.
// The done strobe lasts one cycle and cannot be held off. Capacity writes are
// taken at any time but belong in idle periods.
module bounded_unique_set_table_unit import bust_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  item_t              item,
  output logic               busy,
  output logic               done,
  output result_t            result,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  logic [COUNT_W-1:0] capacity;
  logic [COUNT_W-1:0] cap_eff;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [CMD_W-1:0]   cmd;
  logic               accept;
  probe_t             chain [DEPTH+1];
  probe_t             tail_probe;
  wr_t                wr;
  result_t            result_next;

  assign accept = start && !busy;
  assign cap_eff = (32'(capacity) > DEPTH) ? COUNT_W'(DEPTH) : capacity;

  assign chain[0] = '{valid: accept, value: item.value, hit: 1'b0,
                      hit_slot: '0, tail: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bust_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .count    (count),
      .probe_in (chain[i]),
      .wr       (wr),
      .probe_out(chain[i+1])
    );
  end

  assign tail_probe = chain[DEPTH];

  always_comb begin
    wr          = '{en: 1'b0, slot: '0, data: tail_probe.value};
    count_next  = count;
    result_next = '{status: ST_DONE, slot: '0, entry_count: count};
    if (tail_probe.valid) begin
      case (cmd)
        CMD_INSERT: begin
          if (count >= cap_eff) begin
            result_next.status = ST_FULL;
          end else if (tail_probe.hit) begin
            result_next.status = ST_PRESENT;
            result_next.slot   = tail_probe.hit_slot[SLOT_W-1:0];
          end else begin
            wr.en              = 1'b1;
            wr.slot            = count;
            result_next.slot   = count[SLOT_W-1:0];
            count_next         = count + COUNT_W'(1);
          end
        end
        CMD_REMOVE: begin
          if (tail_probe.hit) begin
            wr.en              = 1'b1;
            wr.slot            = tail_probe.hit_slot;
            wr.data            = tail_probe.tail;
            result_next.slot   = tail_probe.hit_slot[SLOT_W-1:0];
            count_next         = count - COUNT_W'(1);
          end else begin
            result_next.status = ST_ABSENT;
          end
        end
        CMD_LOOKUP: begin
          if (tail_probe.hit) begin
            result_next.slot   = tail_probe.hit_slot[SLOT_W-1:0];
          end else begin
            result_next.status = ST_ABSENT;
          end
        end
        default: begin
          result_next.status = ST_DONE;
        end
      endcase
      result_next.entry_count = count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      count    <= '0;
      busy     <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      count <= count_next;
      done  <= tail_probe.valid;
      if (accept) begin
        busy <= 1'b1;
      end else if (tail_probe.valid) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= item.cmd;
    end
    if (tail_probe.valid) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done raised without a command in progress");

  a_probe_while_busy: assert property (@(posedge clk) disable iff (rst)
    tail_probe.valid |-> busy)
    else $error("probe left the cell row while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= DEPTH)
    else $error("entry count beyond the number of cells");

  a_count_reported: assert property (@(posedge clk) disable iff (rst)
    done |-> result.entry_count == count)
    else $error("reported entry count differs from the held count");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (wr.en && cmd == CMD_INSERT) |-> count < cap_eff)
    else $error("insert written into a full set");
`endif

endmodule
